[src/rsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and the alphabet lookup for the radix string
// converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int SYM_SLOTS   = 32;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 5;
    localparam int BASE_W      = 6;
    localparam int VALUE_W     = 64;
    localparam int CNT_W       = 7;
    localparam int TBL_W       = SYM_SLOTS * SYM_W;

    // bits of the dividend retired per division cycle
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // power of two so that the pointers wrap by themselves
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_3 = 3'd4;

    typedef struct packed {
        logic [BASE_W-1:0] base_size;
        logic [TBL_W-1:0]  symbols;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               bad;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_CHECK
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } back_state_t;

    function automatic logic [SYM_W-1:0] sym_at(input logic [TBL_W-1:0] tbl,
                                                input logic [DIGIT_W-1:0] idx);
        sym_at = tbl[idx*SYM_W +: SYM_W];
    endfunction

endpackage
`default_nettype wire

[src/rsc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_front
// Accepts a value and checks the alphabet, one symbol per cycle against all
// later symbols, then queues the value with its verdict.
// ----------------------------------------------------------------------------
module rsc_front
    import rsc_pkg::*;
#(
    parameter int MAX_BASE = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    busy,
    input  wire cfg_t               cfg,
    input  wire logic               q_full,
    output logic                    push,
    output job_t                    push_job
);

    front_state_t       state_reg, state_next;
    logic [DIGIT_W-1:0] idx_reg, idx_next;
    logic [VALUE_W-1:0] value_reg;

    logic               accept;
    logic               range_ok;
    logic               forbidden;
    logic               dup;
    logic               last_idx;
    logic               step_bad;
    logic [SYM_W-1:0]   cur;

    assign accept = start && !busy;

    always_comb
    begin
        range_ok = (cfg.base_size >= BASE_W'(2))
                && ({1'b0, cfg.base_size} <= (BASE_W+1)'(MAX_BASE))
                && ({1'b0, cfg.base_size} <= (BASE_W+1)'(SYM_SLOTS));
        cur = sym_at(cfg.symbols, idx_reg);
        // nul, whitespace 9..13 and 32, plus and minus
        forbidden = (cur == 8'h00) || ((cur >= 8'h09) && (cur <= 8'h0D))
                 || (cur == 8'h20) || (cur == 8'h2B) || (cur == 8'h2D);
        dup = 1'b0;
        for (int j = 0; j < SYM_SLOTS; j++)
        begin
            if ((DIGIT_W'(j) > idx_reg) && (BASE_W'(j) < cfg.base_size)
                && (sym_at(cfg.symbols, DIGIT_W'(j)) == cur))
            begin
                dup = 1'b1;
            end
        end
        last_idx = ({1'b0, idx_reg} == (cfg.base_size - BASE_W'(1)));
        step_bad = !range_ok || forbidden || dup;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                idx_next = idx_reg + DIGIT_W'(1);
                if (step_bad || last_idx)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy           = (state_reg != F_IDLE) || q_full;
        push           = (state_reg == F_CHECK) && (step_bad || last_idx);
        push_job.value = value_reg;
        push_job.bad   = step_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
    end

endmodule
`default_nettype wire

[src/rsc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_queue
// Short first-in first-out queue of checked jobs between front and back.
// ----------------------------------------------------------------------------
module rsc_queue
    import rsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output job_t      pop_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

[src/rsc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_back
// Divides each job by the radix eight bits per cycle, buffers the digits and
// emits them most significant first; a bad job gives one error word.
// ----------------------------------------------------------------------------
module rsc_back
    import rsc_pkg::*;
#(
    parameter int MAX_DIGITS = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         empty,
    input  wire job_t         pop_job,
    output logic              pop,
    output logic              strobe,
    output logic [SYM_W-1:0]  symbol,
    output logic              last,
    output logic              bad_base
);

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    back_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] word_reg;
    logic [BASE_W-1:0]  part_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  emit_idx_reg;
    logic               rd_valid_reg;
    logic               rd_last_reg;
    logic [DIGIT_W-1:0] mem_q_reg;
    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic               strobe_reg;
    logic [SYM_W-1:0]   symbol_reg;
    logic               last_reg;
    logic               bad_reg;

    logic [VALUE_W-1:0] div_word;
    logic [BASE_W-1:0]  div_rem;
    logic [BASE_W:0]    trial;
    logic               div_done;
    logic               finish;
    logic               load;
    logic               err_out;
    logic               mem_we;
    logic               rd_issue;

    // restoring division, one quotient bit per inner step
    always_comb
    begin
        div_word = word_reg;
        div_rem  = part_reg;
        trial    = '0;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            trial    = {div_rem, div_word[VALUE_W-1]};
            div_word = {div_word[VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, cfg.base_size})
            begin
                trial       = trial - {1'b0, cfg.base_size};
                div_word[0] = 1'b1;
            end
            div_rem = trial[BASE_W-1:0];
        end
        div_done = (step_reg == STEP_W'(DIV_STEPS - 1));
        finish   = div_done && ((div_word == '0)
                 || ((cnt_reg + CNT_W'(1)) == CNT_W'(MAX_DIGITS)));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty && !rd_valid_reg && !pop_job.bad)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (finish)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (emit_idx_reg == '0)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs and strobes
    always_comb
    begin
        // hold off while the last digit read is still in flight
        pop      = (state_reg == B_IDLE) && !empty && !rd_valid_reg;
        load     = pop && !pop_job.bad;
        err_out  = pop && pop_job.bad;
        mem_we   = (state_reg == B_DIV) && div_done;
        rd_issue = (state_reg == B_EMIT);
        strobe   = strobe_reg;
        symbol   = symbol_reg;
        last     = last_reg;
        bad_base = bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            step_reg     <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
            strobe_reg   <= err_out || rd_valid_reg;
            if (load)
            begin
                step_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                step_reg <= div_done ? '0 : step_reg + STEP_W'(1);
                if (div_done)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= pop_job.value;
            part_reg <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            word_reg <= div_word;
            part_reg <= div_done ? '0 : div_rem;
        end
        if (mem_we)
        begin
            emit_idx_reg <= cnt_reg[ADDR_W-1:0];
        end
        else if (rd_issue)
        begin
            emit_idx_reg <= emit_idx_reg - ADDR_W'(1);
        end
        rd_last_reg <= (emit_idx_reg == '0);
        if (err_out)
        begin
            symbol_reg <= '0;
            last_reg   <= 1'b1;
            bad_reg    <= 1'b1;
        end
        else if (rd_valid_reg)
        begin
            symbol_reg <= sym_at(cfg.symbols, mem_q_reg);
            last_reg   <= rd_last_reg;
            bad_reg    <= 1'b0;
        end
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= div_rem[DIGIT_W-1:0];
        end
        if (rd_issue)
        begin
            mem_q_reg <= digit_mem[emit_idx_reg];
        end
    end

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && bad_base |-> last && (symbol == '0))
        else $error("error word without last or with nonzero symbol");

    a_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !rd_valid_reg && (state_reg == B_IDLE))
        else $error("job taken while a digit is still in flight");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

endmodule
`default_nettype wire

[src/radix_string_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radix_string_converter
// Converts a 64-bit unsigned value to text in a configured alphabet, one
// symbol per output word, most significant digit first.
// ----------------------------------------------------------------------------
// flow: the check steps through the alphabet one symbol at a time, up to base_size
//   symbols, then the queue, then the division at 8 dividend bits per cycle; the digits
//   then leave one word per cycle; a bad alphabet gives its single error word after the check
// checking a new value can overlap the division of an earlier one
// reset: asynchronous, clears control and configuration; the digit store is
//   not cleared; the receiver cannot stall, each word is shown for one cycle
// ----------------------------------------------------------------------------
module radix_string_converter
    import rsc_pkg::*;
#(
    parameter int MAX_BASE   = 32,
    parameter int MAX_DIGITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [VALUE_W-1:0]   value,
    output logic                      strobe,
    output logic [SYM_W-1:0]          symbol,
    output logic                      last,
    output logic                      bad_base,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_data
);

    logic [BASE_W-1:0]  base_size_reg;
    logic [VALUE_W-1:0] symbols_reg [4];

    cfg_t cfg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t pop_job;

    assign cfg_ready     = 1'b1;
    assign cfg.base_size = base_size_reg;
    assign cfg.symbols   = {symbols_reg[3], symbols_reg[2], symbols_reg[1], symbols_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                symbols_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_SIZE: base_size_reg  <= cfg_data[BASE_W-1:0];
                REG_SYMBOLS_0: symbols_reg[0] <= cfg_data;
                REG_SYMBOLS_1: symbols_reg[1] <= cfg_data;
                REG_SYMBOLS_2: symbols_reg[2] <= cfg_data;
                REG_SYMBOLS_3: symbols_reg[3] <= cfg_data;
                default:
                begin
                    // unmapped index, word dropped
                end
            endcase
        end
    end

    rsc_front #(
        .MAX_BASE (MAX_BASE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .busy     (busy),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    rsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    rsc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .empty    (q_empty),
        .pop_job  (pop_job),
        .pop      (pop),
        .strobe   (strobe),
        .symbol   (symbol),
        .last     (last),
        .bad_base (bad_base)
    );

endmodule
`default_nettype wire

[tb/rsc_digit_check.sv]
// ----------------------------------------------------------------------------
// rsc_digit_check
// Watches the command, configuration and result channels of the radix string
// converter, predicts the digit words of each accepted value from its own copy
// of the alphabet, and compares every word as it leaves the block.
// ----------------------------------------------------------------------------
module rsc_digit_check
    import rsc_pkg::*;
#(
    parameter int MAX_BASE   = 32,
    parameter int MAX_DIGITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [VALUE_W-1:0]   value,
    input  wire logic                 strobe,
    input  wire logic [SYM_W-1:0]     symbol,
    input  wire logic                 last,
    input  wire logic                 bad_base,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_data,
    output int                        fail_count,
    output int                        pending,
    output int                        values_seen,
    output int                        words_seen,
    output int                        errors_seen
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             bad;
    } digit_word_t;

    digit_word_t       pending_digits[$];
    digit_word_t       head;
    logic [BASE_W-1:0] radix_reg;
    logic [TBL_W-1:0]  alphabet;

    function automatic logic [SYM_W-1:0] glyph(input int d);
        return alphabet[d*SYM_W +: SYM_W];
    endfunction

    function automatic bit alphabet_ok();
        int               n;
        logic [SYM_W-1:0] c;
        n = radix_reg;
        if (n < 2 || n > MAX_BASE || n > SYM_SLOTS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            c = glyph(i);
            // nul, whitespace and sign characters cannot be digits
            if (c == 8'h00 || (c >= 8'h09 && c <= 8'h0d) || c == " " || c == "+" || c == "-")
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (glyph(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_digits(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        int                 n;
        if (!alphabet_ok())
        begin
            pending_digits.push_back('{symbol: '0, last: 1'b1, bad: 1'b1});
            return;
        end
        rest = v;
        n    = 0;
        // least significant digit first, zero still gives one digit
        do
        begin
            digits[n] = DIGIT_W'(rest % radix_reg);
            rest      = rest / radix_reg;
            n++;
        end
        while (rest != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
            pending_digits.push_back('{symbol: glyph(digits[k]), last: (k == 0), bad: 1'b0});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   = '0;
            alphabet    = '0;
            pending_digits.delete();
            fail_count  = 0;
            values_seen = 0;
            words_seen  = 0;
            errors_seen = 0;
        end
        else
        begin
            if (strobe)
            begin
                words_seen++;
                if (bad_base)
                    errors_seen++;
                if (pending_digits.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, %s %h last %b bad_base %b",
                             $time, "got symbol", symbol, last, bad_base);
                end
                else
                begin
                    head = pending_digits.pop_front();
                    if (symbol !== head.symbol || last !== head.last || bad_base !== head.bad)
                    begin
                        fail_count++;
                        $display("%0t: word differs, expected symbol %h last %b bad_base %b,",
                                 $time, head.symbol, head.last, head.bad);
                        $display("%0t:   got symbol %h last %b bad_base %b",
                                 $time, symbol, last, bad_base);
                    end
                end
            end
            if (start && !busy)
            begin
                values_seen++;
                predict_digits(value);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_SIZE: radix_reg = cfg_data[BASE_W-1:0];
                    REG_SYMBOLS_0: alphabet[0*VALUE_W +: VALUE_W] = cfg_data;
                    REG_SYMBOLS_1: alphabet[1*VALUE_W +: VALUE_W] = cfg_data;
                    REG_SYMBOLS_2: alphabet[2*VALUE_W +: VALUE_W] = cfg_data;
                    REG_SYMBOLS_3: alphabet[3*VALUE_W +: VALUE_W] = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = pending_digits.size();
    end

endmodule

[tb/tb_radix_string_converter.sv]
// ----------------------------------------------------------------------------
// tb_radix_string_converter
// Drives values and alphabet settings into the radix string converter: a
// directed pass over radix extremes and every way an alphabet can be rejected,
// then random alphabets and values under varying sender gaps.
// ----------------------------------------------------------------------------
module tb_radix_string_converter;
    import rsc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 600_000;
    localparam int RANDOM_SETS   = 12;
    localparam int VALUES_PER_SET = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [VALUE_W-1:0]   value     = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_SIZE;
    logic [VALUE_W-1:0]   cfg_data  = '0;
    logic                 busy;
    logic                 strobe;
    logic [SYM_W-1:0]     symbol;
    logic                 last;
    logic                 bad_base;
    logic                 cfg_ready;

    int fail_count;
    int pending;
    int values_seen;
    int words_seen;
    int errors_seen;
    int idle_pct      = 22;
    int settings_used = 0;

    always #(HALF_PERIOD) clk = ~clk;

    radix_string_converter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .symbol    (symbol),
        .last      (last),
        .bad_base  (bad_base),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsc_digit_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .strobe      (strobe),
        .symbol      (symbol),
        .last        (last),
        .bad_base    (bad_base),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .values_seen (values_seen),
        .words_seen  (words_seen),
        .errors_seen (errors_seen)
    );

    function automatic logic [TBL_W-1:0] with_byte(input logic [TBL_W-1:0] tbl,
                                                   input int slot,
                                                   input logic [SYM_W-1:0] b);
        tbl[slot*SYM_W +: SYM_W] = b;
        return tbl;
    endfunction

    // consecutive characters from first, random bytes in the unused slots
    function automatic logic [TBL_W-1:0] count_up(input logic [SYM_W-1:0] first, input int n);
        logic [TBL_W-1:0] tbl;
        for (int i = 0; i < SYM_SLOTS; i++)
            tbl[i*SYM_W +: SYM_W] = (i < n) ? SYM_W'(first + i) : SYM_W'($urandom);
        return tbl;
    endfunction

    // distinct bytes from 8'h2e upward, none of them a sign or whitespace
    function automatic logic [TBL_W-1:0] random_alphabet(input int n);
        logic [TBL_W-1:0] tbl;
        bit [255:0]       used;
        logic [SYM_W-1:0] c;
        used = '0;
        for (int i = 0; i < SYM_SLOTS; i++)
        begin
            if (i < n)
            begin
                do
                    c = SYM_W'($urandom_range(46, 255));
                while (used[c]);
                used[c] = 1'b1;
            end
            else
                c = SYM_W'($urandom);
            tbl[i*SYM_W +: SYM_W] = c;
        end
        return tbl;
    endfunction

    function automatic logic [SYM_W-1:0] rejected_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return SYM_W'($urandom_range(9, 13));
            2: return " ";
            default: return $urandom_range(0, 1) ? "+" : "-";
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return r;
            1: return VALUE_W'($urandom_range(0, 40));
            2: return $urandom_range(0, 1) ? {VALUE_W{1'b1}} : {VALUE_W{1'b0}};
            default: return r >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_alphabet(input logic [BASE_W-1:0] radix, input logic [TBL_W-1:0] tbl);
        logic [VALUE_W-1:0] junk;
        start = 1'b0;
        drain();
        junk = {$urandom, $urandom};
        write_reg(REG_BASE_SIZE, {junk[VALUE_W-1:BASE_W], radix});
        write_reg(REG_SYMBOLS_0, tbl[0*VALUE_W +: VALUE_W]);
        write_reg(REG_SYMBOLS_1, tbl[1*VALUE_W +: VALUE_W]);
        write_reg(REG_SYMBOLS_2, tbl[2*VALUE_W +: VALUE_W]);
        write_reg(REG_SYMBOLS_3, tbl[3*VALUE_W +: VALUE_W]);
        // indexes past the last register must not alias onto one
        if ($urandom_range(0, 1))
            write_reg(REG_SYMBOLS_3 + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        if ($urandom_range(1, 100) <= idle_pct)
        begin
            start = 1'b0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(20, 80)) @(negedge clk);
            else
                repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start = 1'b1;
        value = v;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        logic [TBL_W-1:0]  tbl;
        logic [TBL_W-1:0]  dec;
        int                n;
        int                i;
        int                j;
        int                per_set;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty alphabet straight out of reset
        send_value(64'd12345);

        dec = count_up("0", 10);
        load_alphabet(6'd10, dec);
        send_value('0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value({VALUE_W{1'b1}});
        send_value(64'h8000_0000_0000_0000);

        // a space just past the used symbols is harmless
        load_alphabet(6'd10, with_byte(dec, 10, " "));
        send_value(64'd255);

        load_alphabet(6'd2, count_up("0", 2));
        send_value({VALUE_W{1'b1}});
        send_value('0);
        send_value(64'd1);

        load_alphabet(6'd32, count_up("@", 32));
        send_value({VALUE_W{1'b1}});
        send_value(64'h0123_4567_89ab_cdef);

        // bytes right next to the rejected ones are legal digits
        tbl = random_alphabet(6);
        tbl = with_byte(tbl, 0, 8'h01);
        tbl = with_byte(tbl, 1, 8'h08);
        tbl = with_byte(tbl, 2, 8'h0e);
        tbl = with_byte(tbl, 3, 8'h1f);
        tbl = with_byte(tbl, 4, 8'h21);
        tbl = with_byte(tbl, 5, 8'h2c);
        load_alphabet(6'd6, tbl);
        send_value(64'hfedc_ba98_7654_3210);

        // rejected alphabets
        load_alphabet(6'd1, dec);
        send_value(64'd77);
        load_alphabet(6'd33, count_up("@", 32));
        send_value(64'd77);
        load_alphabet(6'd63, count_up("@", 32));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 3, "0"));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 5, 8'h09));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 9, 8'h0d));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 0, " "));
        send_value('0);
        load_alphabet(6'd10, with_byte(dec, 4, "+"));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 7, "-"));
        send_value(64'd77);
        load_alphabet(6'd10, with_byte(dec, 2, 8'h00));
        send_value(64'd77);

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            idle_pct = (s < RANDOM_SETS / 3) ? 22 : (s < 2 * RANDOM_SETS / 3) ? 60 : 0;
            case ($urandom_range(0, 3))
                0: n = 2;
                1: n = 32;
                default: n = $urandom_range(2, 32);
            endcase
            tbl     = random_alphabet(n);
            per_set = VALUES_PER_SET;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    i       = $urandom_range(1, n - 1);
                    j       = $urandom_range(0, i - 1);
                    tbl     = with_byte(tbl, i, tbl[j*SYM_W +: SYM_W]);
                    per_set = 4;
                end
                2:
                begin
                    tbl     = with_byte(tbl, $urandom_range(0, n - 1), rejected_byte());
                    per_set = 4;
                end
                3:
                begin
                    n       = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
                    per_set = 4;
                end
                default: ;
            endcase
            load_alphabet(BASE_W'(n), tbl);
            repeat (per_set) send_value(random_value());
        end

        start = 1'b0;
        drain();
        $display("converted %0d values under %0d alphabet settings", values_seen, settings_used);
        $display("checked %0d digit words, %0d of them alphabet errors", words_seen, errors_seen);
        if (fail_count == 0)
            $display("radix_string_converter: match");
        else
            $display("radix_string_converter: mismatch");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("timeout with %0d words outstanding", pending);
        $display("radix_string_converter: mismatch");
        $finish;
    end

endmodule

[radix_string_converter.f]
src/rsc_pkg.sv
src/rsc_front.sv
src/rsc_queue.sv
src/rsc_back.sv
src/radix_string_converter.sv
tb/rsc_digit_check.sv
tb/tb_radix_string_converter.sv
